// ----- rtl/sobm_pkg.sv -----
// Package with the widths, limits and register indexes of the Sobel edge magnitude block.
package sobm_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 12;
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int GRAD_W     = PIX_W + 3;
	localparam int MAG_W      = PIX_W + 3;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);
	localparam logic [PIX_W-1:0]    PIX_MAX      = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

endpackage

// ----- rtl/sobm_pix_if.sv -----
// Interface for the pixel request channel.
interface sobm_pix_if
	import sobm_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             frame_start;

	modport source (output valid, output pixel_value, output frame_start, input ready);
	modport sink (input valid, input pixel_value, input frame_start, output ready);
endinterface

// ----- rtl/sobm_edge_if.sv -----
// Interface for the edge magnitude result channel.
interface sobm_edge_if
	import sobm_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] edge_magnitude;
	logic [ROW_W-1:0] centre_row;
	logic [COL_W-1:0] centre_col;
	logic             frame_last;

	modport source (output valid, output edge_magnitude, output centre_row,
		output centre_col, output frame_last, input ready);
	modport sink (input valid, input edge_magnitude, input centre_row,
		input centre_col, input frame_last, output ready);
endinterface

// ----- rtl/sobel_edge_magnitude_3x3.sv -----
// 3x3 Sobel L1 edge magnitude over a raster pixel stream with two line memories.
// Throughput: one pixel per cycle unless the result channel stalls.
// The line memories are read at acceptance and written when the pixel leaves the
// first stage, with forwarding between the two.
// Reset clears position counters, window, pipeline valids and configuration
// (width 640, height 480); the line memories are not cleared.
module sobel_edge_magnitude_3x3
	import sobm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sobm_pix_if.sink              pix_in,
	sobm_edge_if.source           edge_out
);

	logic [PIX_W-1:0] mem_upper [MAX_WIDTH];
	logic [PIX_W-1:0] mem_middle [MAX_WIDTH];

	logic [WIDTH_W-1:0]  width_eff_q;
	logic [HEIGHT_W-1:0] height_eff_q;
	logic [ROW_W-1:0]    row_count_q;
	logic [COL_W-1:0]    col_count_q;
	logic [PIX_W-1:0]    win_q [6];

	logic                s1_valid_s1;
	logic [PIX_W-1:0]    pix_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [COL_W-1:0]    col_s1;
	logic                emit_s1;
	logic                last_s1;
	logic [PIX_W-1:0]    rd_upper_s1;
	logic [PIX_W-1:0]    rd_middle_s1;
	logic                fwd_s1;
	logic [PIX_W-1:0]    fwd_upper_s1;
	logic [PIX_W-1:0]    fwd_middle_s1;

	logic                       valid_s2;
	logic signed [GRAD_W-1:0]   gx_s2;
	logic signed [GRAD_W-1:0]   gy_s2;
	logic [ROW_W-1:0]           row_s2;
	logic [COL_W-1:0]           col_s2;
	logic                       last_s2;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_mag_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_last_q;

	logic accept;
	logic s1_fire;
	logic s2_ready;
	logic out_ready;

	logic [ROW_W-1:0]    row0;
	logic [COL_W-1:0]    col0;
	logic [WIDTH_W-1:0]  col_inc;
	logic                col_wrap;
	logic [HEIGHT_W-1:0] row_inc;
	logic [HEIGHT_W-1:0] row_next;
	logic [COL_W-1:0]    col_next;

	logic [PIX_W-1:0] p02;
	logic [PIX_W-1:0] p12;
	logic [GRAD_W-1:0] sum_right;
	logic [GRAD_W-1:0] sum_left;
	logic [GRAD_W-1:0] sum_bottom;
	logic [GRAD_W-1:0] sum_top;

	logic [GRAD_W-1:0] abs_gx;
	logic [GRAD_W-1:0] abs_gy;
	logic [MAG_W-1:0]  mag;

	// Configuration registers hold the clamped effective sizes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_eff_q  <= WIDTH_RESET;
			height_eff_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: begin
					if (cfg_data[WIDTH_W-1:0] < WIDTH_W'(3))
						width_eff_q <= WIDTH_W'(3);
					else if (cfg_data[WIDTH_W-1:0] > WIDTH_MAX)
						width_eff_q <= WIDTH_MAX;
					else
						width_eff_q <= cfg_data[WIDTH_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					if (cfg_data < HEIGHT_W'(3))
						height_eff_q <= HEIGHT_W'(3);
					else if (cfg_data > HEIGHT_MAX)
						height_eff_q <= HEIGHT_MAX;
					else
						height_eff_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_ready = !out_valid_q || edge_out.ready;
	assign s2_ready  = !valid_s2 || out_ready;
	assign s1_fire   = s1_valid_s1 && (!emit_s1 || s2_ready);
	assign pix_in.ready = !s1_valid_s1 || s1_fire;
	assign accept    = pix_in.valid && pix_in.ready;

	always_comb begin
		row0 = pix_in.frame_start ? '0 : row_count_q;
		col0 = pix_in.frame_start ? '0 : col_count_q;
		col_inc  = {1'b0, col0} + WIDTH_W'(1);
		col_wrap = (col_inc >= width_eff_q);
		col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
		row_inc  = {1'b0, row0} + HEIGHT_W'(col_wrap);
		row_next = (row_inc >= height_eff_q) ? '0 : row_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			col_count_q <= '0;
			s1_valid_s1 <= 1'b0;
			fwd_s1      <= 1'b0;
		end else begin
			if (accept) begin
				row_count_q <= row_next[ROW_W-1:0];
				col_count_q <= col_next;
				fwd_s1      <= s1_fire && (col_s1 == col0);
				s1_valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1        <= pix_in.pixel_value;
			row_s1        <= row0;
			col_s1        <= col0;
			emit_s1       <= (row0 >= ROW_W'(2)) && (col0 >= COL_W'(2));
			last_s1       <= ({1'b0, row0} == height_eff_q - HEIGHT_W'(1)) &&
				({1'b0, col0} == width_eff_q - WIDTH_W'(1));
			fwd_upper_s1  <= p12;
			fwd_middle_s1 <= pix_s1;
		end
	end

	// Line memories: read at acceptance, written as the pixel leaves the first stage.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_upper_s1  <= mem_upper[col0];
			rd_middle_s1 <= mem_middle[col0];
		end
		if (s1_fire) begin
			mem_upper[col_s1]  <= p12;
			mem_middle[col_s1] <= pix_s1;
		end
	end

	always_comb begin
		p02 = fwd_s1 ? fwd_upper_s1 : rd_upper_s1;
		p12 = fwd_s1 ? fwd_middle_s1 : rd_middle_s1;
		sum_right  = GRAD_W'(p02) + (GRAD_W'(p12) << 1) + GRAD_W'(pix_s1);
		sum_left   = GRAD_W'(win_q[0]) + (GRAD_W'(win_q[1]) << 1) + GRAD_W'(win_q[2]);
		sum_bottom = GRAD_W'(win_q[2]) + (GRAD_W'(win_q[5]) << 1) + GRAD_W'(pix_s1);
		sum_top    = GRAD_W'(win_q[0]) + (GRAD_W'(win_q[3]) << 1) + GRAD_W'(p02);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (s1_fire) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= p02;
			win_q[4] <= p12;
			win_q[5] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= s1_fire && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready) begin
			gx_s2   <= $signed(sum_right - sum_left);
			gy_s2   <= $signed(sum_bottom - sum_top);
			row_s2  <= row_s1 - ROW_W'(1);
			col_s2  <= col_s1 - COL_W'(1);
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		abs_gx = gx_s2[GRAD_W-1] ? GRAD_W'(-gx_s2) : GRAD_W'(gx_s2);
		abs_gy = gy_s2[GRAD_W-1] ? GRAD_W'(-gy_s2) : GRAD_W'(gy_s2);
		mag    = MAG_W'(abs_gx) + MAG_W'(abs_gy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			out_mag_q  <= (mag > MAG_W'(PIX_MAX)) ? PIX_MAX : mag[PIX_W-1:0];
			out_row_q  <= row_s2;
			out_col_q  <= col_s2;
			out_last_q <= last_s2;
		end
	end

	assign edge_out.valid          = out_valid_q;
	assign edge_out.edge_magnitude = out_mag_q;
	assign edge_out.centre_row     = out_row_q;
	assign edge_out.centre_col     = out_col_q;
	assign edge_out.frame_last     = out_last_q;

endmodule
